FILE: src/md5inv_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5inv_pkg
// Constants, types and helper functions for the MD5 inverse step pipeline.
// ---------------------------------------------------------------------------
package md5inv_pkg;

   localparam int WORD_W  = 32;
   localparam int STEP_W  = 6;
   localparam int SHIFT_W = 5;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [STEP_W-1:0]  step_type;
   typedef logic [SHIFT_W-1:0] shift_type;

   typedef enum logic [1:0] {
      ROUND_F = 2'd0,
      ROUND_G = 2'd1,
      ROUND_H = 2'd2,
      ROUND_I = 2'd3
   } round_type;

   localparam word_type INIT_WORDS [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam shift_type ROT_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   localparam word_type K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   function automatic word_type swap_bytes(input word_type x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic word_type round_fn(input round_type r, input word_type b,
                                         input word_type c, input word_type d);
      word_type f;
      unique case (r)
         ROUND_F: f = (b & c) | (~b & d);
         ROUND_G: f = (d & b) | (~d & c);
         ROUND_H: f = b ^ c ^ d;
         ROUND_I: f = c ^ (b | ~d);
         default: f = '0;
      endcase
      return f;
   endfunction

   function automatic word_type rot_right(input word_type x, input shift_type s);
      logic [2*WORD_W-1:0] dbl;
      dbl = {x, x} >> s;
      return dbl[WORD_W-1:0];
   endfunction

endpackage

FILE: src/md5_inverse_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_inverse_step
// Four-stage pipeline that undoes one MD5 compression step.
// ---------------------------------------------------------------------------
// A word is taken at every clock edge where start is high; busy never rises,
// so one word per cycle is sustained. Each result appears on the rsp_ ports
// with rsp_valid high for one cycle, and must be captured then. Each word
// passes through four register stages: digest preparation, difference/round
// function/constant lookup, rotate and constant subtract, final round
// function subtract.
module md5_inverse_step
   import md5inv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  word_type req_state_a,
   input  word_type req_state_b,
   input  word_type req_state_c,
   input  word_type req_state_d,
   input  step_type req_step_index,
   input  logic     req_from_digest,
   output logic     rsp_valid,
   output word_type rsp_prev_b,
   output word_type rsp_prev_c,
   output word_type rsp_prev_d,
   output word_type rsp_a_plus_word
);

   // stage 1: digest preparation
   logic     s1_valid_ff;
   word_type s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff;
   word_type s1_a_in, s1_b_in, s1_c_in, s1_d_in;
   step_type s1_step_ff;

   // stage 2: difference, round function, constant
   logic      s2_valid_ff;
   word_type  s2_pb_ff, s2_pc_ff, s2_pd_ff, s2_diff_ff, s2_func_ff, s2_k_ff;
   shift_type s2_rot_ff;
   word_type  s2_diff_in, s2_func_in, s2_k_in;
   shift_type s2_rot_in;

   // stage 3: rotate, subtract constant
   logic     s3_valid_ff;
   word_type s3_pb_ff, s3_pc_ff, s3_pd_ff, s3_acc_ff, s3_func_ff;
   word_type s3_acc_in;

   // stage 4: output register
   logic     s4_valid_ff;
   word_type s4_pb_ff, s4_pc_ff, s4_pd_ff, s4_acc_ff;
   word_type s4_acc_in;

   assign busy = 1'b0;

   always_comb begin
      if (req_from_digest) begin
         s1_a_in = swap_bytes(req_state_a) - INIT_WORDS[0];
         s1_b_in = swap_bytes(req_state_b) - INIT_WORDS[1];
         s1_c_in = swap_bytes(req_state_c) - INIT_WORDS[2];
         s1_d_in = swap_bytes(req_state_d) - INIT_WORDS[3];
      end else begin
         s1_a_in = req_state_a;
         s1_b_in = req_state_b;
         s1_c_in = req_state_c;
         s1_d_in = req_state_d;
      end
   end

   always_comb begin
      s2_diff_in = s1_b_ff - s1_c_ff;
      s2_func_in = round_fn(round_type'(s1_step_ff[5:4]), s1_c_ff, s1_d_ff, s1_a_ff);
      s2_k_in    = K_TABLE[s1_step_ff];
      s2_rot_in  = ROT_TABLE[{s1_step_ff[5:4], s1_step_ff[1:0]}];
   end

   assign s3_acc_in = rot_right(s2_diff_ff, s2_rot_ff) - s2_k_ff;
   assign s4_acc_in = s3_acc_ff - s3_func_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_a_ff    <= s1_a_in;
      s1_b_ff    <= s1_b_in;
      s1_c_ff    <= s1_c_in;
      s1_d_ff    <= s1_d_in;
      s1_step_ff <= req_step_index;

      s2_pb_ff   <= s1_c_ff;
      s2_pc_ff   <= s1_d_ff;
      s2_pd_ff   <= s1_a_ff;
      s2_diff_ff <= s2_diff_in;
      s2_func_ff <= s2_func_in;
      s2_k_ff    <= s2_k_in;
      s2_rot_ff  <= s2_rot_in;

      s3_pb_ff   <= s2_pb_ff;
      s3_pc_ff   <= s2_pc_ff;
      s3_pd_ff   <= s2_pd_ff;
      s3_acc_ff  <= s3_acc_in;
      s3_func_ff <= s2_func_ff;

      s4_pb_ff   <= s3_pb_ff;
      s4_pc_ff   <= s3_pc_ff;
      s4_pd_ff   <= s3_pd_ff;
      s4_acc_ff  <= s4_acc_in;
   end

   assign rsp_valid       = s4_valid_ff;
   assign rsp_prev_b      = s4_pb_ff;
   assign rsp_prev_c      = s4_pc_ff;
   assign rsp_prev_d      = s4_pd_ff;
   assign rsp_a_plus_word = s4_acc_ff;

endmodule

FILE: src/md5inv_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5inv_checker
// Port-level timing and pass-through checks for the MD5 inverse step.
// ---------------------------------------------------------------------------
module md5inv_checker
   import md5inv_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     start,
   input logic     busy,
   input word_type req_state_a,
   input logic     req_from_digest,
   input logic     rsp_valid,
   input word_type rsp_prev_d
);

   // every taken word yields a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##4 rsp_valid)
      else $error("result missing four cycles after accept");

   // no result without a matching taken word
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, 4))
      else $error("result without matching accept");

   // pipeline never pushes back
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   // raw words: previous D is the incoming A
   a_prev_d: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(!req_from_digest, 4) |-> rsp_prev_d == $past(req_state_a, 4))
      else $error("prev_d does not match state_a");

endmodule

bind md5_inverse_step md5inv_checker u_md5inv_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_state_a     (req_state_a),
   .req_from_digest (req_from_digest),
   .rsp_valid       (rsp_valid),
   .rsp_prev_d      (rsp_prev_d)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for md5_inverse_step: directed words, then random bursts,
// each accepted word is predicted by an independent model of the inverse
// MD5 step, and every strobed result is compared in order.
// ---------------------------------------------------------------------------
module tb;
   import md5inv_pkg::*;

   typedef struct packed {
      word_type prev_b;
      word_type prev_c;
      word_type prev_d;
      word_type a_plus_word;
   } undo_result_type;

   class step_scoreboard;
      undo_result_type pending_undo[$];
      int              fails;

      localparam word_type STEP_CONST [64] = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
      };

      localparam int SHIFT_AMT [16] = '{
         7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
      };

      localparam word_type IV [4] = '{
         32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
      };

      function new();
         fails = 0;
      endfunction

      function word_type digest_word(input word_type x, input int idx);
         word_type sw;
         sw = {x[7:0], x[15:8], x[23:16], x[31:24]};
         return sw - IV[idx];
      endfunction

      function undo_result_type undo_step(input word_type a, input word_type b,
                                          input word_type c, input word_type d,
                                          input step_type step, input logic dig);
         word_type        wa, wb, wc, wd, diff, rot, mix;
         int              sh;
         round_type       rnd;
         undo_result_type r;
         wa = dig ? digest_word(a, 0) : a;
         wb = dig ? digest_word(b, 1) : b;
         wc = dig ? digest_word(c, 2) : c;
         wd = dig ? digest_word(d, 3) : d;
         sh   = SHIFT_AMT[{step[5:4], step[1:0]}];
         diff = wb - wc;
         rot  = (diff >> sh) | (diff << (32 - sh));
         rnd  = round_type'(step[5:4]);
         case (rnd)
            ROUND_F: mix = (wc & wd) | (~wc & wa);
            ROUND_G: mix = (wa & wc) | (~wa & wd);
            ROUND_H: mix = wc ^ wd ^ wa;
            default: mix = wd ^ (wc | ~wa);
         endcase
         r.prev_b      = wc;
         r.prev_c      = wd;
         r.prev_d      = wa;
         r.a_plus_word = rot - STEP_CONST[step] - mix;
         return r;
      endfunction

      function void note_word(input word_type a, input word_type b,
                              input word_type c, input word_type d,
                              input step_type step, input logic dig);
         pending_undo.push_back(undo_step(a, b, c, d, step, dig));
      endfunction

      function void check_result(input undo_result_type got);
         undo_result_type exp;
         if (pending_undo.size() == 0) begin
            $error("unexpected result word %h", got);
            fails++;
         end else begin
            exp = pending_undo.pop_front();
            if (got.prev_b !== exp.prev_b) begin
               $error("prev_b: expected %h, got %h", exp.prev_b, got.prev_b);
               fails++;
            end
            if (got.prev_c !== exp.prev_c) begin
               $error("prev_c: expected %h, got %h", exp.prev_c, got.prev_c);
               fails++;
            end
            if (got.prev_d !== exp.prev_d) begin
               $error("prev_d: expected %h, got %h", exp.prev_d, got.prev_d);
               fails++;
            end
            if (got.a_plus_word !== exp.a_plus_word) begin
               $error("a_plus_word: expected %h, got %h",
                      exp.a_plus_word, got.a_plus_word);
               fails++;
            end
         end
      endfunction

      function int pending();
         return pending_undo.size();
      endfunction
   endclass

   localparam int RANDOM_WORDS = 1850;

   logic     clock = 1'b0;
   logic     reset;
   logic     start;
   logic     busy;
   word_type req_state_a, req_state_b, req_state_c, req_state_d;
   step_type req_step_index;
   logic     req_from_digest;
   logic     rsp_valid;
   word_type rsp_prev_b, rsp_prev_c, rsp_prev_d, rsp_a_plus_word;

   step_scoreboard sb;

   md5_inverse_step u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_state_a     (req_state_a),
      .req_state_b     (req_state_b),
      .req_state_c     (req_state_c),
      .req_state_d     (req_state_d),
      .req_step_index  (req_step_index),
      .req_from_digest (req_from_digest),
      .rsp_valid       (rsp_valid),
      .rsp_prev_b      (rsp_prev_b),
      .rsp_prev_c      (rsp_prev_c),
      .rsp_prev_d      (rsp_prev_d),
      .rsp_a_plus_word (rsp_a_plus_word)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (sb != null && !reset) begin
         if (start && !busy)
            sb.note_word(req_state_a, req_state_b, req_state_c, req_state_d,
                         req_step_index, req_from_digest);
         if (rsp_valid)
            sb.check_result({rsp_prev_b, rsp_prev_c, rsp_prev_d, rsp_a_plus_word});
      end
   end

   // hold the word until it is taken
   task automatic send_word(input word_type a, input word_type b,
                            input word_type c, input word_type d,
                            input step_type step, input logic dig);
      req_state_a     <= a;
      req_state_b     <= b;
      req_state_c     <= c;
      req_state_d     <= d;
      req_step_index  <= step;
      req_from_digest <= dig;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic word_type pick_word();
      case ($urandom_range(9, 0))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(31, 0);
         3: return word_type'($urandom_range(255, 0));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int burst_len;
      int sent;
      int drain;
      int s;
      sb = new();
      reset           <= 1'b1;
      start           <= 1'b0;
      req_state_a     <= '0;
      req_state_b     <= '0;
      req_state_c     <= '0;
      req_state_d     <= '0;
      req_step_index  <= '0;
      req_from_digest <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // round boundaries, extreme words, wrap of B - C
      send_word('0, '0, '0, '0, 6'd0, 1'b0);
      send_word('1, '1, '1, '1, 6'd63, 1'b0);
      send_word(32'h0, 32'h0, 32'h1, 32'h0, 6'd15, 1'b0);
      send_word('1, 32'h0, '1, 32'h0, 6'd16, 1'b0);
      send_word(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h87654321, 6'd31, 1'b0);
      send_word(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h1, 6'd32, 1'b0);
      send_word(32'haaaaaaaa, 32'h55555555, 32'hcccccccc, 32'h33333333, 6'd47, 1'b0);
      send_word(32'hdeadbeef, 32'hcafebabe, 32'h0badf00d, 32'hfeedface, 6'd48, 1'b0);
      idle_gap(3);
      // digest path: swapped initial values give zero words
      send_word(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210, 6'd0, 1'b1);
      send_word(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210, 6'd63, 1'b1);
      send_word('0, '0, '0, '0, 6'd33, 1'b1);
      send_word('1, '1, '1, '1, 6'd17, 1'b1);
      send_word(32'h11223344, 32'h55667788, 32'h99aabbcc, 32'hddeeff00, 6'd50, 1'b1);
      for (s = 0; s < 4; s++)
         send_word($urandom, $urandom, $urandom, $urandom, step_type'(s * 16 + 3), 1'b1);
      idle_gap(1);

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst_len = $urandom_range(24, 1);
         for (int k = 0; k < burst_len && sent < RANDOM_WORDS; k++) begin
            send_word(pick_word(), pick_word(), pick_word(), pick_word(),
                      step_type'($urandom_range(63, 0)), 1'($urandom_range(1, 0)));
            sent++;
         end
         if ($urandom_range(9, 0) < 3)
            idle_gap(0);
         else
            idle_gap($urandom_range(12, 1));
      end
      start <= 1'b0;

      drain = 0;
      while (sb.pending() != 0 && drain < 200) begin
         @(posedge clock);
         drain++;
      end
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.fails += sb.pending();
      end
      repeat (8) @(posedge clock);
      #1;
      if (sb.fails == 0)
         $display("md5_inverse_step verification clean");
      else
         $display("md5_inverse_step verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("md5_inverse_step verification failed");
      $finish;
   end

endmodule

FILE: md5_inverse_step.f
src/md5inv_pkg.sv
src/md5_inverse_step.sv
src/md5inv_checker.sv
sim/tb.sv
